// File: sv/tvks_pkg.sv
`timescale 1ns / 1ps
// Shared types, status codes and key helpers for the triangle vertex key sorter.
// No dependencies; imported by tvks_cell and triangle_vertex_key_sorter.
package tvks_pkg;

    localparam int VTX_W        = 31;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 256;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef logic [VTX_W-1:0] vtx_t;

    typedef struct packed {
        logic command;
        vtx_t vertex_a;
        vtx_t vertex_b;
        vtx_t vertex_c;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        vtx_t                out_a;
        vtx_t                out_b;
        vtx_t                out_c;
        logic                final_one;
    } out_t;

    // vertices in original order
    typedef struct packed {
        vtx_t a;
        vtx_t b;
        vtx_t c;
    } tri_t;

    // ascending vertex indices, k0 smallest
    typedef struct packed {
        vtx_t k0;
        vtx_t k1;
        vtx_t k2;
    } key_t;

    typedef struct packed {
        tri_t verts;
        key_t key;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t new_entry;
    } cell_ctl_t;

    function automatic key_t order3(input tri_t t);
        vtx_t x0;
        vtx_t x1;
        vtx_t x2;
        vtx_t tmp;
        key_t k;
        x0 = t.a;
        x1 = t.b;
        x2 = t.c;
        if (x1 < x0) begin
            tmp = x0; x0 = x1; x1 = tmp;
        end
        if (x2 < x1) begin
            tmp = x1; x1 = x2; x2 = tmp;
        end
        if (x1 < x0) begin
            tmp = x0; x0 = x1; x1 = tmp;
        end
        k.k0 = x0;
        k.k1 = x1;
        k.k2 = x2;
        return k;
    endfunction

    // true when key x sorts strictly after key y
    function automatic logic key_gt(input key_t x, input key_t y);
        logic r;
        if (x.k0 != y.k0) begin
            r = x.k0 > y.k0;
        end else if (x.k1 != y.k1) begin
            r = x.k1 > y.k1;
        end else begin
            r = x.k2 > y.k2;
        end
        return r;
    endfunction

endpackage

// File: sv/tvks_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds a triangle and its key, compares against
// the broadcast key and shifts with its neighbors. Depends on tvks_pkg.
module tvks_cell #(
    parameter int CNT_W = 9,
    parameter int IDX   = 0
) (
    input  logic               aclk,
    input  tvks_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]   count,
    input  tvks_pkg::entry_t   left_entry,
    input  logic               left_after,
    input  tvks_pkg::entry_t   right_entry,
    output tvks_pkg::entry_t   entry,
    output logic               after
);
    import tvks_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = count > IDX_C;
    // empty slots act as an infinitely large key
    assign after    = !occupied || key_gt(entry_reg.key, ctl.new_entry.key);

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins && after) begin
            entry_next = left_after ? left_entry : ctl.new_entry;
        end else if (ctl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: sv/triangle_vertex_key_sorter.sv
`timescale 1ns / 1ps
// Triangle vertex key sorter top level: input stage, chain of tvks_cell slots,
// fill counter and result register. Depends on tvks_pkg and tvks_cell.
//
// Usage:
//   s_valid/s_ready/s_data carry commands: insert a triangle or pop the
//   triangle with the smallest ascending-index key. Equal keys leave in
//   insertion order. Every beat in gives exactly one result beat on
//   m_valid/m_ready/m_data: status plus, for a pop, the triangle in its
//   original vertex order and final_one when the store became empty.
//   A command passes the input stage register, then the result register.
//   Throughput is one command per cycle while the receiver keeps up: the
//   key of a new triangle is sorted in the input stage, then all CAPACITY
//   cells compare against it and shift by one slot in parallel, for both insert and pop.
//   When the receiver stalls, the result register holds its beat, the input
//   stage fills, and s_ready drops until m_ready returns; nothing is lost.
//   Reset (aresetn low, synchronous) empties the store and both stages.
//   Inserting into a full store returns status full and changes nothing;
//   popping an empty store returns status empty.
module triangle_vertex_key_sorter #(
    parameter int CAPACITY = tvks_pkg::CAPACITY_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tvks_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tvks_pkg::out_t m_data
);
    import tvks_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    // input stage
    logic   stg_valid_reg;
    logic   stg_valid_next;
    logic   stg_cmd_reg;
    entry_t stg_entry_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic m_valid_reg;
    logic m_valid_next;
    out_t m_data_reg;
    out_t m_data_next;

    logic      advance;
    logic      full;
    logic      empty;
    cell_ctl_t ctl;

    entry_t cell_entry [CAPACITY];
    logic   cell_after [CAPACITY];

    assign advance = stg_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stg_valid_reg || advance;
    assign full    = count_reg == CAP_C;
    assign empty   = count_reg == '0;

    assign ctl.ins       = advance && (stg_cmd_reg == CMD_INSERT) && !full;
    assign ctl.pop       = advance && (stg_cmd_reg == CMD_POP) && !empty;
    assign ctl.new_entry = stg_entry_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            entry_t left_e;
            logic   left_a;
            entry_t right_e;
            if (gi == 0) begin : g_first
                assign left_e = '0;
                assign left_a = 1'b0;
            end else begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_a = cell_after[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_body
                assign right_e = cell_entry[gi+1];
            end
            tvks_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .count       (count_reg),
                .left_entry  (left_e),
                .left_after  (left_a),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .after       (cell_after[gi])
            );
        end
    endgenerate

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (s_ready) begin
            stg_valid_next = s_valid;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + ONE_C;
        end else if (ctl.pop) begin
            count_next = count_reg - ONE_C;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            if (stg_cmd_reg == CMD_INSERT) begin
                m_data_next.status = full ? ST_FULL : ST_INSERTED;
            end else if (empty) begin
                m_data_next.status = ST_EMPTY;
            end else begin
                m_data_next.status    = ST_POPPED;
                m_data_next.out_a     = cell_entry[0].verts.a;
                m_data_next.out_b     = cell_entry[0].verts.b;
                m_data_next.out_c     = cell_entry[0].verts.c;
                m_data_next.final_one = count_reg == ONE_C;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            stg_cmd_reg           <= s_data.command;
            stg_entry_reg.verts.a <= s_data.vertex_a;
            stg_entry_reg.verts.b <= s_data.vertex_b;
            stg_entry_reg.verts.c <= s_data.vertex_c;
            stg_entry_reg.key     <= order3('{a: s_data.vertex_a, b: s_data.vertex_b,
                                              c: s_data.vertex_c});
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("fill count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins |=> count_reg == $past(count_reg) + ONE_C)
        else $error("insert did not grow the store");

    a_head_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(2) |-> !key_gt(cell_entry[0].key, cell_entry[1].key))
        else $error("head slots out of key order");

    a_non_pop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status != ST_POPPED |->
            m_data_reg.out_a == '0 && m_data_reg.final_one == 1'b0)
        else $error("non-pop result carries data");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> stg_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");
`endif

endmodule

// File: dv/triangle_vertex_key_sorter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for triangle_vertex_key_sorter: directed table, then
// random insert/pop traffic checked against a sorted-store predictor. Needs tvks_pkg.
module triangle_vertex_key_sorter_tb;
    import tvks_pkg::*;

    localparam int   CAP       = CAPACITY_DEF;
    localparam int   N_ROWS    = 23;
    localparam int   LONG_HOLD = 60;
    localparam int   LIMIT     = 400000;
    localparam vtx_t VTX_MAX   = '1;

    typedef struct {
        in_t  beat;
        logic typed;
        out_t want;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    entry_t held_tris[$];
    out_t   pending_results[$];
    tri_t   last_tri = '0;
    int     insert_mix[4] = '{80, 45, 70, 30};
    bit     calm;
    bit     hold_req;
    int     cycle_count;
    int     mismatch_count;
    int     n_inserts;
    int     n_pops;
    int     n_full;
    int     n_empty;
    int     peak_fill;

    triangle_vertex_key_sorter #(
        .CAPACITY(CAP)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // ascending key; the median falls out of xor once min and max are removed
    function automatic key_t ascending_key(input tri_t t);
        vtx_t lo;
        vtx_t hi;
        key_t k;
        lo = (t.a < t.b) ? t.a : t.b;
        lo = (t.c < lo) ? t.c : lo;
        hi = (t.a > t.b) ? t.a : t.b;
        hi = (t.c > hi) ? t.c : hi;
        k.k0 = lo;
        k.k1 = t.a ^ t.b ^ t.c ^ lo ^ hi;
        k.k2 = hi;
        return k;
    endfunction

    // applies one command to the predicted store and returns its result beat
    function automatic out_t next_sorter_result(input in_t beat);
        out_t   r;
        entry_t e;
        int     pos;
        r = '0;
        if (beat.command == CMD_INSERT) begin
            if (held_tris.size() >= CAP) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                e.verts.a = beat.vertex_a;
                e.verts.b = beat.vertex_b;
                e.verts.c = beat.vertex_c;
                e.key     = ascending_key(e.verts);
                pos = held_tris.size();
                // packed key compares k0 first, then k1, then k2; ties stay FIFO
                while (pos > 0 && held_tris[pos-1].key > e.key) pos--;
                held_tris.insert(pos, e);
                r.status = ST_INSERTED;
                n_inserts++;
                if (held_tris.size() > peak_fill) peak_fill = held_tris.size();
            end
        end else if (held_tris.size() == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
        end else begin
            e = held_tris.pop_front();
            r.status    = ST_POPPED;
            r.out_a     = e.verts.a;
            r.out_b     = e.verts.b;
            r.out_c     = e.verts.c;
            r.final_one = (held_tris.size() == 0);
            n_pops++;
        end
        return r;
    endfunction

    function automatic stim_row_t tab_row(input logic cmd, input vtx_t a, input vtx_t b,
                                          input vtx_t c, input logic typed,
                                          input logic [STATUS_W-1:0] st, input vtx_t oa,
                                          input vtx_t ob, input vtx_t oc, input logic fin);
        stim_row_t row;
        row.beat.command  = cmd;
        row.beat.vertex_a = a;
        row.beat.vertex_b = b;
        row.beat.vertex_c = c;
        row.typed          = typed;
        row.want.status    = st;
        row.want.out_a     = oa;
        row.want.out_b     = ob;
        row.want.out_c     = oc;
        row.want.final_one = fin;
        return row;
    endfunction

    function automatic vtx_t pick_vertex();
        vtx_t v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = VTX_MAX;
            2, 3, 4: v = vtx_t'($urandom_range(0, 7));
            5:       v = VTX_MAX - vtx_t'($urandom_range(0, 7));
            default: v = vtx_t'($urandom());
        endcase
        return v;
    endfunction

    function automatic in_t random_beat(input int insert_pct);
        in_t beat;
        beat.command  = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP;
        beat.vertex_a = pick_vertex();
        beat.vertex_b = pick_vertex();
        beat.vertex_c = pick_vertex();
        if (beat.command == CMD_INSERT) begin
            if ($urandom_range(0, 5) == 0) begin
                // same key as the previous triangle, vertices rotated
                beat.vertex_a = last_tri.b;
                beat.vertex_b = last_tri.c;
                beat.vertex_c = last_tri.a;
            end
            last_tri.a = beat.vertex_a;
            last_tri.b = beat.vertex_b;
            last_tri.c = beat.vertex_c;
        end
        return beat;
    endfunction

    task automatic send_beat(input in_t beat, input logic typed, input out_t typed_want);
        out_t want;
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = next_sorter_result(beat);
        if (typed) want = typed_want;
        pending_results.push_back(want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int insert_pct);
        send_beat(random_beat(insert_pct), 1'b0, '0);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input vtx_t want_v, input vtx_t got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // result beat checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", vtx_t'(want.status), vtx_t'(m_data.status));
                check_field("out_a", want.out_a, m_data.out_a);
                check_field("out_b", want.out_b, m_data.out_b);
                check_field("out_c", want.out_c, m_data.out_c);
                check_field("final_one", vtx_t'(want.final_one), vtx_t'(m_data.final_one));
            end
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("Timed out after %0d cycles with %0d results pending",
                 cycle_count, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        stim_row_t directed_rows[N_ROWS];
        int        i;

        directed_rows[0]  = tab_row(CMD_POP, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
        directed_rows[1]  = tab_row(CMD_INSERT, VTX_MAX, VTX_MAX, VTX_MAX, 1,
                                    ST_INSERTED, 0, 0, 0, 0);
        directed_rows[2]  = tab_row(CMD_INSERT, 0, 0, 0, 1, ST_INSERTED, 0, 0, 0, 0);
        directed_rows[3]  = tab_row(CMD_POP, VTX_MAX, 0, VTX_MAX, 1, ST_POPPED, 0, 0, 0, 0);
        directed_rows[4]  = tab_row(CMD_POP, 0, 0, 0, 1,
                                    ST_POPPED, VTX_MAX, VTX_MAX, VTX_MAX, 1);
        directed_rows[5]  = tab_row(CMD_POP, VTX_MAX, VTX_MAX, VTX_MAX, 1,
                                    ST_EMPTY, 0, 0, 0, 0);
        // three orderings of one key: must come back in arrival order
        directed_rows[6]  = tab_row(CMD_INSERT, 5, 1, 3, 1, ST_INSERTED, 0, 0, 0, 0);
        directed_rows[7]  = tab_row(CMD_INSERT, 3, 5, 1, 1, ST_INSERTED, 0, 0, 0, 0);
        directed_rows[8]  = tab_row(CMD_INSERT, 1, 3, 5, 1, ST_INSERTED, 0, 0, 0, 0);
        directed_rows[9]  = tab_row(CMD_INSERT, 2, 9, 0, 1, ST_INSERTED, 0, 0, 0, 0);
        directed_rows[10] = tab_row(CMD_INSERT, VTX_MAX, 0, 31'h5555_5555, 1,
                                    ST_INSERTED, 0, 0, 0, 0);
        directed_rows[11] = tab_row(CMD_INSERT, 31'h2AAA_AAAA, 31'h7FFF_FFFE, 1, 1,
                                    ST_INSERTED, 0, 0, 0, 0);
        directed_rows[12] = tab_row(CMD_INSERT, 4, 4, 1, 1, ST_INSERTED, 0, 0, 0, 0);
        for (i = 13; i < 20; i++) begin
            directed_rows[i] = tab_row(CMD_POP, vtx_t'(i), 0, 0, 0, ST_POPPED, 0, 0, 0, 0);
        end
        directed_rows[20] = tab_row(CMD_POP, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
        directed_rows[21] = tab_row(CMD_INSERT, 31'h4000_0000, 31'h3FFF_FFFF,
                                    31'h4000_0000, 1, ST_INSERTED, 0, 0, 0, 0);
        directed_rows[22] = tab_row(CMD_POP, 0, 0, 0, 0, ST_POPPED, 0, 0, 0, 0);

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_ROWS; i++) begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        end

        // mixed traffic, store depth wandering with the insert share
        foreach (insert_mix[m]) begin
            repeat (75) send_random(insert_mix[m]);
        end

        // empty the store, then fill past capacity with the result side held off once
        while (held_tris.size() != 0) send_random(0);
        for (i = 0; i < CAP + 3; i++) begin
            if (i == 40) hold_req = 1'b1;
            send_random(100);
        end
        wait_all_results();
        for (i = 0; i < CAP + 2; i++) send_random(0);

        // tail: no idling on either side
        calm = 1'b1;
        repeat (300) send_random(55);

        wait_all_results();
        repeat (8) @(posedge aclk);

        $display("Covered %0d inserts, %0d pops, %0d full-store drops, %0d empty-store pops",
                 n_inserts, n_pops, n_full, n_empty);
        $display("Deepest store: %0d of %0d triangles", peak_fill, CAP);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
